// ----- hw/rtl/hmt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hmt_pkg;

    localparam int HOSTS = 16;
    localparam int IDX_W = $clog2(HOSTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HOSTS - 1);

    localparam int CNT_W = 5;
    localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;
    localparam logic [31:0] BEATS_MAX = 32'h7fff_ffff;
    localparam logic [31:0] BEATS_INIT = 32'd2;
    localparam logic [8:0] RING_SIZE = 9'd360;

    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_OWN_INDEX = 2'd0;
    localparam logic [1:0] REG_OWN_RING_ID = 2'd1;
    localparam logic [1:0] REG_FAIL_TIMEOUT = 2'd2;
    localparam logic [1:0] REG_REMOVE_TIMEOUT = 2'd3;

    typedef enum logic [1:0] {
        OP_MERGE = 2'd0,
        OP_BEAT  = 2'd1,
        OP_TICK  = 2'd2,
        OP_INIT  = 2'd3
    } t_op;

    typedef struct packed {
        logic        valid;
        logic        up;
        logic [31:0] beats;
        logic [8:0]  ring_id;
        logic [31:0] seen;
    } t_slot;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        t_slot            data;
    } t_slot_wr;

    typedef struct packed {
        logic [3:0]  own_index;
        logic [8:0]  own_ring_id;
        logic [15:0] fail_timeout;
        logic [15:0] remove_timeout;
    } t_cfg;

    typedef struct packed {
        logic [31:0] diff;
        logic        gt;
        logic        ge_fail;
        logic        ge_rem;
        logic        at_max;
    } t_alu_res;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c < COUNT_MAX) ? c + 1'b1 : COUNT_MAX;
    endfunction

    function automatic logic [8:0] ring_mod(input logic [8:0] v);
        return (v >= RING_SIZE) ? v - RING_SIZE : v;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/hmt_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface hmt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [3:0]  entry_slot;
    logic        entry_is_valid;
    logic        entry_is_up;
    logic signed [31:0] entry_beats;
    logic [8:0]  entry_ring_id;
    logic        last_entry;
    logic        reorder_pending;

    modport source (
        output valid, operation, entry_slot, entry_is_valid, entry_is_up,
               entry_beats, entry_ring_id, last_entry, reorder_pending,
        input  ready
    );
    modport sink (
        input  valid, operation, entry_slot, entry_is_valid, entry_is_up,
               entry_beats, entry_ring_id, last_entry, reorder_pending,
        output ready
    );
endinterface

interface hmt_out_if;
    logic       valid;
    logic       ready;
    logic       entry_adopted;
    logic [4:0] live_count;
    logic       set_reorder;
    logic [4:0] newly_down;
    logic [4:0] removed_count;

    modport source (
        output valid, entry_adopted, live_count, set_reorder, newly_down, removed_count,
        input  ready
    );
    modport sink (
        input  valid, entry_adopted, live_count, set_reorder, newly_down, removed_count,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/heartbeat_membership_table.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Membership table of HOSTS slots for a gossip heartbeat failure detector.
// Every input word (merge, own heartbeat, tick or initialize) sweeps all
// slots, one slot per cycle through a single shared subtract and compare
// unit. A new word is taken only after the last: idle accepts it, sweep
// walks the HOSTS slots, hold passes the result to the output register,
// where it may wait while the next word is taken. Time is a tick counter
// that a tick word advances by one. The user is to write configuration
// over the register port between words; the block itself does not enforce
// it. Reads return the current register values.

module heartbeat_membership_table
    import hmt_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    hmt_in_if.sink                  i_in,
    hmt_out_if.source               o_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    t_cfg             cfg;
    t_slot            cur;
    t_slot_wr         slot_wr;
    t_alu_res         alu_res;
    t_op              op;
    logic [IDX_W-1:0] rd_idx;
    logic [31:0]      beats;
    logic [31:0]      now;

    hmt_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (cfg)
    );

    hmt_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (rd_idx),
        .i_wr     (slot_wr),
        .o_cur    (cur)
    );

    hmt_alu u_alu (
        .i_op    (op),
        .i_cur   (cur),
        .i_beats (beats),
        .i_now   (now),
        .i_cfg   (cfg),
        .o_res   (alu_res)
    );

    hmt_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_out    (o_out),
        .i_cfg    (cfg),
        .i_cur    (cur),
        .i_alu    (alu_res),
        .o_rd_idx (rd_idx),
        .o_wr     (slot_wr),
        .o_op     (op),
        .o_beats  (beats),
        .o_now    (now)
    );

    // table only changes during a sweep
    a_wr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        slot_wr.en |-> !i_in.ready)
        else $error("table written while idle");

    // sweep pointer follows the read index
    a_wr_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        slot_wr.en |-> (slot_wr.idx == rd_idx))
        else $error("table write away from sweep pointer");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("word accepted without a sweep");

    a_result_after_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(!i_in.ready))
        else $error("result word without a sweep");

endmodule

`default_nettype wire

// ----- hw/rtl/hmt_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hmt_cfg
    import hmt_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_psel,
    input  wire logic               i_penable,
    input  wire logic               i_pwrite,
    input  wire logic [PADDR_W-1:0] i_paddr,
    input  wire logic [31:0]        i_pwdata,
    output logic [31:0]             o_prdata,
    output logic                    o_pready,
    output t_cfg                    o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign reg_sel  = i_paddr[3:2];
    assign wr_en    = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_index      <= 4'd0;
            r_cfg.own_ring_id    <= 9'd0;
            r_cfg.fail_timeout   <= 16'd5;
            r_cfg.remove_timeout <= 16'd10;
        end else if (wr_en) begin
            case (reg_sel)
                REG_OWN_INDEX:      r_cfg.own_index      <= i_pwdata[3:0];
                REG_OWN_RING_ID:    r_cfg.own_ring_id    <= i_pwdata[8:0];
                REG_FAIL_TIMEOUT:   r_cfg.fail_timeout   <= i_pwdata[15:0];
                REG_REMOVE_TIMEOUT: r_cfg.remove_timeout <= i_pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_OWN_INDEX:      o_prdata = {28'd0, r_cfg.own_index};
            REG_OWN_RING_ID:    o_prdata = {23'd0, r_cfg.own_ring_id};
            REG_FAIL_TIMEOUT:   o_prdata = {16'd0, r_cfg.fail_timeout};
            REG_REMOVE_TIMEOUT: o_prdata = {16'd0, r_cfg.remove_timeout};
            default:            o_prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/hmt_table.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hmt_table
    import hmt_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [IDX_W-1:0] i_rd_idx,
    input  wire t_slot_wr         i_wr,
    output t_slot                 o_cur
);

    t_slot r_slots [HOSTS];

    assign o_cur = r_slots[i_rd_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HOSTS; i++) begin
                r_slots[i] <= '0;
            end
        end else if (i_wr.en) begin
            r_slots[i_wr.idx] <= i_wr.data;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/hmt_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hmt_alu
    import hmt_pkg::*;
(
    input  wire t_op         i_op,
    input  wire t_slot       i_cur,
    input  wire logic [31:0] i_beats,
    input  wire logic [31:0] i_now,
    input  wire t_cfg        i_cfg,
    output t_alu_res         o_res
);

    logic [32:0] opa;
    logic [32:0] opb;
    logic [32:0] diff;

    always_comb begin
        case (i_op)
            OP_MERGE: begin
                opa = {i_beats[31], i_beats};
                opb = {i_cur.beats[31], i_cur.beats};
            end
            OP_BEAT: begin
                // subtracting all ones adds one
                opa = {1'b0, i_cur.beats};
                opb = '1;
            end
            OP_TICK: begin
                opa = {1'b0, i_now};
                opb = {1'b0, i_cur.seen};
            end
            default: begin
                opa = '0;
                opb = '0;
            end
        endcase
        diff          = opa - opb;
        o_res.diff    = diff[31:0];
        o_res.gt      = !diff[32] && (diff[31:0] != 32'd0);
        o_res.ge_fail = (diff[31:16] != 16'd0) || (diff[15:0] >= i_cfg.fail_timeout);
        o_res.ge_rem  = (diff[31:16] != 16'd0) || (diff[15:0] >= i_cfg.remove_timeout);
        o_res.at_max  = (i_cur.beats == BEATS_MAX);
    end

endmodule

`default_nettype wire

// ----- hw/rtl/hmt_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hmt_seq
    import hmt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    hmt_in_if.sink          i_in,
    hmt_out_if.source       o_out,
    input  wire t_cfg       i_cfg,
    input  wire t_slot      i_cur,
    input  wire t_alu_res   i_alu,
    output logic [IDX_W-1:0] o_rd_idx,
    output t_slot_wr        o_wr,
    output t_op             o_op,
    output logic [31:0]     o_beats,
    output logic [31:0]     o_now
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_HOLD
    } t_state;

    t_state           r_state;
    logic [IDX_W-1:0] r_idx;
    t_op              r_op;
    logic [3:0]       r_slot;
    logic             r_ev;
    logic             r_eu;
    logic [31:0]      r_beats;
    logic [8:0]       r_ring;
    logic             r_last;
    logic             r_pend;
    logic [31:0]      r_now;
    logic [CNT_W-1:0] r_member;
    logic [CNT_W-1:0] r_prev;
    logic [CNT_W-1:0] r_live;
    logic [CNT_W-1:0] r_down;
    logic [CNT_W-1:0] r_rem;
    logic             r_adopt;
    logic             r_reorder;

    logic             r_out_valid;
    logic             r_o_adopt;
    logic [CNT_W-1:0] r_o_live;
    logic             r_o_reorder;
    logic [CNT_W-1:0] r_o_down;
    logic [CNT_W-1:0] r_o_rem;

    t_slot            n_slot;
    logic             wr_en;
    logic [CNT_W-1:0] n_live;
    logic [CNT_W-1:0] n_down;
    logic [CNT_W-1:0] n_rem;
    logic [CNT_W-1:0] n_member;
    logic             n_adopt;
    logic             slot_hit;
    logic             own_hit;

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.entry_adopted = r_o_adopt;
    assign o_out.live_count    = r_o_live;
    assign o_out.set_reorder   = r_o_reorder;
    assign o_out.newly_down    = r_o_down;
    assign o_out.removed_count = r_o_rem;

    assign o_rd_idx = r_idx;
    assign o_op     = r_op;
    assign o_beats  = r_beats;
    assign o_now    = r_now;
    assign o_wr.en   = wr_en && (r_state == S_SWEEP);
    assign o_wr.idx  = r_idx;
    assign o_wr.data = n_slot;

    assign slot_hit = (32'(r_idx) == 32'(r_slot));
    assign own_hit  = (32'(r_idx) == 32'(i_cfg.own_index));

    // per-slot update for the slot under the sweep pointer
    always_comb begin
        n_slot   = i_cur;
        wr_en    = 1'b0;
        n_down   = r_down;
        n_rem    = r_rem;
        n_member = r_member;
        n_adopt  = r_adopt;
        case (r_op)
            OP_MERGE: begin
                if (slot_hit && r_ev && r_eu && i_alu.gt) begin
                    n_slot.valid   = 1'b1;
                    n_slot.up      = 1'b1;
                    n_slot.beats   = r_beats;
                    n_slot.ring_id = i_cur.valid ? i_cur.ring_id : r_ring;
                    n_slot.seen    = r_now;
                    wr_en          = 1'b1;
                    n_adopt        = 1'b1;
                end
            end
            OP_BEAT: begin
                if (own_hit) begin
                    if (!i_alu.at_max) begin
                        n_slot.beats = i_alu.diff;
                    end
                    n_slot.seen = r_now;
                    wr_en       = 1'b1;
                end
            end
            OP_TICK: begin
                if (i_cur.valid) begin
                    if (i_alu.ge_fail) begin
                        if (i_cur.up) begin
                            n_down = sat_inc(r_down);
                        end
                        n_slot.up = 1'b0;
                        wr_en     = 1'b1;
                    end
                    if (i_alu.ge_rem) begin
                        n_slot = '0;
                        n_rem  = sat_inc(r_rem);
                        if (r_member != '0) begin
                            n_member = r_member - 1'b1;
                        end
                        wr_en = 1'b1;
                    end
                end
            end
            OP_INIT: begin
                wr_en = 1'b1;
                if (own_hit) begin
                    n_slot.valid   = 1'b1;
                    n_slot.up      = 1'b1;
                    n_slot.beats   = BEATS_INIT;
                    n_slot.ring_id = ring_mod(i_cfg.own_ring_id);
                    n_slot.seen    = r_now;
                end else begin
                    n_slot       = '0;
                    n_slot.beats = '1;
                end
            end
            default: ;
        endcase
        n_live = (n_slot.valid && n_slot.up) ? sat_inc(r_live) : r_live;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_now       <= '0;
            r_member    <= '0;
            r_prev      <= '0;
        end else begin
            if (r_out_valid && o_out.ready && r_state != S_HOLD) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_op      <= t_op'(i_in.operation);
                        r_slot    <= i_in.entry_slot;
                        r_ev      <= i_in.entry_is_valid;
                        r_eu      <= i_in.entry_is_up;
                        r_beats   <= i_in.entry_beats;
                        r_ring    <= i_in.entry_ring_id;
                        r_last    <= i_in.last_entry;
                        r_pend    <= i_in.reorder_pending;
                        r_idx     <= '0;
                        r_live    <= '0;
                        r_down    <= '0;
                        r_rem     <= '0;
                        r_adopt   <= 1'b0;
                        r_reorder <= 1'b0;
                        if (t_op'(i_in.operation) == OP_TICK) begin
                            r_now <= r_now + 32'd1;
                        end
                        r_state <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    r_live  <= n_live;
                    r_down  <= n_down;
                    r_rem   <= n_rem;
                    r_adopt <= n_adopt;
                    r_idx   <= r_idx + 1'b1;
                    if (r_idx == LAST_IDX && r_op == OP_MERGE && r_last) begin
                        // message end: recount and compare
                        r_member <= n_live;
                        if (n_live != r_prev && !r_pend) begin
                            r_reorder <= 1'b1;
                            r_prev    <= n_live;
                        end
                    end else begin
                        r_member <= n_member;
                    end
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_o_adopt   <= r_adopt;
                        r_o_live    <= r_live;
                        r_o_reorder <= r_reorder;
                        r_o_down    <= r_down;
                        r_o_rem     <= r_rem;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire
